// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/stbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  localparam int CODE_W  = 21;
  localparam int INDEX_W = 8;
  localparam int MATCH_W = 16;
  localparam int COUNT_W = 9;

  localparam logic [MATCH_W-1:0] NOT_FOUND_INDEX = 16'hFFFF;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic               lookup;
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  code;
  } op_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] index;
  } res_t;

endpackage

`default_nettype wire

// ===== src/stbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_front #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           cmd,
  input  wire logic [stbs_pkg::INDEX_W-1:0]   entry_index,
  input  wire logic [stbs_pkg::CODE_W-1:0]    code_value,
  output logic                                op_valid,
  output stbs_pkg::op_t                       op,
  input  wire logic                           op_pop
);

  stbs_pkg::op_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          in_range;
  logic          enq;

  // writes past the table end are taken and dropped here
  assign in_range = 17'(entry_index) < 17'(TABLE_DEPTH);
  assign full     = cnt == 2'd2;
  assign enq      = push && !full && (cmd == stbs_pkg::CMD_LOOKUP || in_range);
  assign op_valid = cnt != 2'd0;
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{lookup: cmd == stbs_pkg::CMD_LOOKUP, index: entry_index,
                     code: code_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (op_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({enq, op_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/stbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    count,
  input  wire logic                                op_valid,
  input  wire stbs_pkg::op_t                       op,
  output logic                                     op_pop,
  output logic                                     res_push,
  output stbs_pkg::res_t                           res,
  input  wire logic                                res_full
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [stbs_pkg::CODE_W-1:0]  mem [TABLE_DEPTH];
  logic [stbs_pkg::CODE_W-1:0]  rd_data;
  logic [stbs_pkg::CODE_W-1:0]  key;
  logic [CNT_W-1:0]             low;
  logic [CNT_W-1:0]             hi_end;   // exclusive upper bound
  logic [ADDR_W-1:0]            mid;
  logic [CNT_W-1:0]             mid_ext;
  logic [CNT_W-1:0]             low_next;
  logic [CNT_W-1:0]             end_next;
  logic                         probe_eq;
  logic                         probe_gt;
  logic                         range_left;
  logic                         start_lookup;
  logic                         wr_en;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;

  assign op_pop       = state == ST_IDLE && op_valid;
  assign start_lookup = op_pop && op.lookup;
  assign wr_en        = op_pop && !op.lookup;

  assign mid_ext    = CNT_W'(mid);
  assign probe_eq   = rd_data == key;
  assign probe_gt   = rd_data > key;
  assign low_next   = probe_gt ? low : mid_ext + CNT_W'(1);
  assign end_next   = probe_gt ? mid_ext : hi_end;
  assign range_left = low_next < end_next;

  // midpoint = low + (high - low) / 2 with high = end - 1
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = ADDR_W'((count - CNT_W'(1)) >> 1);
      rd_en   = start_lookup && count != '0;
    end else begin
      rd_addr = ADDR_W'(low_next + ((end_next - low_next - CNT_W'(1)) >> 1));
      rd_en   = state == ST_PROBE && !probe_eq && range_left;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(op.index)] <= op.code;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        state_next = ST_IDLE;
        if (start_lookup) begin
          state_next = (count == '0) ? ST_HOLD : ST_PROBE;
        end
      end
      ST_PROBE: state_next = (probe_eq || !range_left) ? ST_HOLD : ST_PROBE;
      ST_HOLD:  state_next = res_full ? ST_HOLD : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid <= rd_addr;
    end
    if (start_lookup) begin
      key    <= op.code;
      low    <= '0;
      hi_end <= count;
      res    <= '{found: 1'b0, index: stbs_pkg::NOT_FOUND_INDEX};
    end else if (state == ST_PROBE) begin
      low    <= low_next;
      hi_end <= end_next;
      if (probe_eq) begin
        res <= '{found: 1'b1, index: stbs_pkg::MATCH_W'(mid)};
      end
    end
  end

  assign res_push = state == ST_HOLD;

endmodule

`default_nettype wire

// ===== src/stbs_rq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_rq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          res_push,
  input  wire stbs_pkg::res_t                res,
  output logic                               res_full,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               found,
  output logic [stbs_pkg::MATCH_W-1:0]       match_index
);

  stbs_pkg::res_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           enq;
  logic           deq;

  assign res_full    = cnt == 2'd2;
  assign empty       = cnt == 2'd0;
  assign enq         = res_push && !res_full;
  assign deq         = pop && !empty;
  assign found       = q[rd_ptr].found;
  assign match_index = q[rd_ptr].index;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({enq, deq})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search_top.sv =====
// Binary search over a sorted table of 21-bit codepoints.
// Input queue port: push/full with cmd, entry_index, code_value. cmd write stores
// code_value at entry_index (writes at or past TABLE_DEPTH are dropped) and gives
// no result; cmd lookup searches the first entry_count entries.
// Result queue port: empty/pop with found and match_index (65535 when not found).
// entry_count is set through cfg_we/cfg_wdata; the user must write it only while
// idle, the block does not enforce this. Values past TABLE_DEPTH are clamped.
// Entries must be written before a lookup can probe them. A write is stored as it
// leaves the command queue. A lookup issues its first read as it leaves, if
// entry_count is nonzero, probes the table and pushes its result from the hold
// state. It makes at most clog2(TABLE_DEPTH)+1 probes (nine for 256 entries),
// one probe per cycle, bounded by the single read port of the table memory. The
// engine works on one beat at a time: writes go at one a cycle while it is idle.
// A two-beat command queue and a two-beat result queue decouple both sides; a
// stalled receiver fills the result queue, holds the search engine and then
// raises full. Reset empties both queues and clears entry_count to zero; table
// contents are kept undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            cmd,
  input  wire logic [stbs_pkg::INDEX_W-1:0]    entry_index,
  input  wire logic [stbs_pkg::CODE_W-1:0]     code_value,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 found,
  output logic [stbs_pkg::MATCH_W-1:0]         match_index,
  input  wire logic                            cfg_we,
  input  wire logic [stbs_pkg::COUNT_W-1:0]    cfg_wdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [16:0]      count_sat;
  logic             op_valid;
  stbs_pkg::op_t    op;
  logic             op_pop;
  logic             res_push;
  stbs_pkg::res_t   res;
  logic             res_full;

  assign count_sat = (17'(cfg_wdata) > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH)
                                                          : 17'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_we) begin
      count <= CNT_W'(count_sat);
    end
  end

  stbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .entry_index (entry_index),
    .code_value  (code_value),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop)
  );

  stbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .count    (count),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  stbs_rq u_rq (
    .clk         (clk),
    .rst         (rst),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full),
    .empty       (empty),
    .pop         (pop),
    .found       (found),
    .match_index (match_index)
  );

endmodule

`default_nettype wire

// ===== src/stbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stbs_props #(
  parameter int TABLE_DEPTH = 256
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          full,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic                          found,
  input wire logic [stbs_pkg::MATCH_W-1:0]  match_index
);

  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty && !full)
  `ASSERT_NEXT(a_hold_stalled, clk, rst, !empty && !pop, !empty && $stable(found) && $stable(match_index))
  `ASSERT_IMPLIES(a_miss_index, clk, rst, !empty && !found, match_index == stbs_pkg::NOT_FOUND_INDEX)
  `ASSERT_IMPLIES(a_hit_range, clk, rst, !empty && found, 17'(match_index) < 17'(TABLE_DEPTH))

endmodule

bind sorted_table_binary_search_top stbs_props #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .found       (found),
  .match_index (match_index)
);

`default_nettype wire
